// File: sv/b59_pkg.sv
// ----------------------------------------------------------------------------
// b59_pkg
// Shared constants, sequencer state type and digit character table for the
// base-59 group encoder.
// ----------------------------------------------------------------------------
package b59_pkg;

  // group and digit geometry
  localparam int GROUP_BITS = 47;
  localparam int RADIX      = 59;
  localparam int DIGITS     = 8;
  localparam int DIGIT_W    = 6;
  localparam int CHAR_W     = 7;

  // bit collector
  localparam int BUF_W = 54;
  localparam int CNT_W = 6;

  // long division: dividend register and bits retired per cycle
  localparam int WORK_W    = 48;
  localparam int STEP_BITS = 4;
  localparam int STEPS     = WORK_W / STEP_BITS;
  localparam int STEP_CW   = 4;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // ascii code of each base-59 digit, digit 0 first
  localparam logic [CHAR_W-1:0] DIGIT_CHARS [RADIX] = '{
    7'd10,  7'd121, 7'd61,  7'd123, 7'd57,  7'd44,  7'd53,  7'd55,  7'd48,  7'd49,
    7'd50,  7'd51,  7'd52,  7'd54,  7'd56,  7'd102, 7'd117, 7'd110, 7'd99,  7'd116,
    7'd105, 7'd111, 7'd91,  7'd108, 7'd115, 7'd104, 7'd114, 7'd97,  7'd98,  7'd100,
    7'd101, 7'd103, 7'd106, 7'd107, 7'd109, 7'd112, 7'd113, 7'd118, 7'd119, 7'd120,
    7'd122, 7'd33,  7'd35,  7'd37,  7'd40,  7'd41,  7'd93,  7'd125, 7'd60,  7'd62,
    7'd43,  7'd47,  7'd42,  7'd58,  7'd59,  7'd46,  7'd126, 7'd95,  7'd32
  };

  // map a digit to its character, codes past the radix read as zero
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    c = '0;
    if (d < DIGIT_W'(RADIX)) c = DIGIT_CHARS[d];
    return c;
  endfunction

endpackage

// File: sv/b59_div_step.sv
// ----------------------------------------------------------------------------
// b59_div_step
// Shared remainder unit: retires STEP_BITS dividend bits of a long division by
// 59 per cycle, giving the updated remainder and the new quotient bits.
// ----------------------------------------------------------------------------
module b59_div_step
  import b59_pkg::*;
(
  input  logic [DIGIT_W-1:0]   rem_in,
  input  logic [STEP_BITS-1:0] bits_in,   // dividend bits, most significant first
  output logic [DIGIT_W-1:0]   rem_out,
  output logic [STEP_BITS-1:0] quot_out
);

  // restoring division, one bit after another
  always_comb begin
    logic [DIGIT_W:0] r;
    r = {1'b0, rem_in};
    quot_out = '0;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      r = {r[DIGIT_W-1:0], bits_in[i]};
      if (r >= (DIGIT_W+1)'(RADIX)) begin
        r = r - (DIGIT_W+1)'(RADIX);
        quot_out[i] = 1'b1;
      end
    end
    rem_out = r[DIGIT_W-1:0];
  end

endmodule

// File: sv/base59_group_encoder_core.sv
// ----------------------------------------------------------------------------
// base59_group_encoder_core
// Packs a byte stream lsb first into 47-bit groups and turns each group into
// eight base-59 characters, least significant digit first.
// ----------------------------------------------------------------------------
// A byte that completes no group and is not final is merged into the
// collector and the block stays idle. A byte that yields a group keeps the
// block busy until all eight characters of the group (up to two groups on a
// final byte) have reached the output register, and longer while the output
// is stalled: each digit is one pass through the shared remainder unit, which
// retires 4 dividend bits a cycle, then the character moves into the output
// register. s_tready is low while a group is being converted. On the final
// byte (s_tlast) leftover bits are zero padded into one more group and the
// collector restarts empty; m_tlast marks the last character caused by a byte.
module base59_group_encoder_core
  import b59_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // final_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [6:0] char_code, [7] zero
  output logic       m_tlast    // run_last
);

  state_t              state;
  logic [BUF_W-1:0]    bit_buffer;
  logic [CNT_W-1:0]    bit_count;
  logic [WORK_W-1:0]   work;
  logic [DIGIT_W-1:0]  rem;
  logic [STEP_CW-1:0]  step;
  logic [2:0]          digit;
  logic                last_group;
  logic                fin_pending;

  logic                accept;
  logic                slot_free;
  logic [BUF_W-1:0]    merged;
  logic [CNT_W-1:0]    cnt_sum;
  logic [CNT_W-1:0]    cnt_left;
  logic                full_group;
  logic [DIGIT_W-1:0]  rem_next;
  logic [STEP_BITS-1:0] quot_bits;

  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;

  // bits above the count are always zero, so the new byte is simply or-ed in
  assign merged     = bit_buffer | (BUF_W'(s_tdata) << bit_count);
  assign cnt_sum    = bit_count + CNT_W'(8);
  assign full_group = (cnt_sum >= CNT_W'(GROUP_BITS));
  assign cnt_left   = cnt_sum - CNT_W'(GROUP_BITS);

  // shared remainder unit
  b59_div_step u_div (
    .rem_in   (rem),
    .bits_in  (work[WORK_W-1 -: STEP_BITS]),
    .rem_out  (rem_next),
    .quot_out (quot_bits)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      bit_buffer  <= '0;
      bit_count   <= '0;
      m_tvalid    <= 1'b0;
      fin_pending <= 1'b0;
      last_group  <= 1'b0;
      step        <= '0;
      digit       <= '0;
      rem         <= '0;
    end else begin
      // output register: load on a character, clear once taken
      if ((state == ST_EMIT) && slot_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            rem   <= '0;
            step  <= '0;
            digit <= '0;
            if (full_group) begin
              work        <= WORK_W'(merged[GROUP_BITS-1:0]);
              bit_buffer  <= merged >> GROUP_BITS;
              bit_count   <= cnt_left;
              fin_pending <= s_tlast;
              last_group  <= !(s_tlast && (cnt_left != '0));
              state       <= ST_DIV;
            end else if (s_tlast && (cnt_sum != '0)) begin
              work        <= WORK_W'(merged[GROUP_BITS-1:0]);
              bit_buffer  <= '0;
              bit_count   <= '0;
              fin_pending <= 1'b0;
              last_group  <= 1'b1;
              state       <= ST_DIV;
            end else if (s_tlast) begin
              bit_buffer <= '0;
              bit_count  <= '0;
            end else begin
              bit_buffer <= merged;
              bit_count  <= cnt_sum;
            end
          end
        end
        ST_DIV: begin
          rem  <= rem_next;
          work <= {work[WORK_W-STEP_BITS-1:0], quot_bits};
          step <= step + STEP_CW'(1);
          if (step == STEP_CW'(STEPS - 1)) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            m_tdata  <= {1'b0, digit_char(rem)};
            m_tlast  <= last_group && (digit == 3'(DIGITS - 1));
            rem      <= '0;
            step     <= '0;
            if (digit != 3'(DIGITS - 1)) begin
              digit <= digit + 3'd1;
              state <= ST_DIV;
            end else if (fin_pending && (bit_count != '0)) begin
              // padded group of the leftover bits
              work        <= WORK_W'(bit_buffer[GROUP_BITS-1:0]);
              bit_buffer  <= '0;
              bit_count   <= '0;
              fin_pending <= 1'b0;
              last_group  <= 1'b1;
              digit       <= '0;
              state       <= ST_DIV;
            end else begin
              if (fin_pending) begin
                bit_buffer <= '0;
                bit_count  <= '0;
              end
              fin_pending <= 1'b0;
              state       <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // division pass never runs past its last step
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (step <= STEP_CW'(STEPS - 1)))
    else $error("division step counter out of range");

  // collector never holds a full group while waiting for a byte
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (bit_count < CNT_W'(GROUP_BITS)))
    else $error("bit count holds a full group while idle");

  // bits above the count stay clear
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ((bit_buffer >> bit_count) == '0))
    else $error("stale bits above bit count");

  // the character that ends a byte's output returns the block to idle
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && slot_free && digit == 3'(DIGITS - 1) && last_group)
      |=> (state == ST_IDLE) && m_tvalid && m_tlast)
    else $error("last character did not end the request");
`endif

endmodule

// File: test/base59_char_checker.sv
// ----------------------------------------------------------------------------
// base59_char_checker
// Watches both stream channels of the base-59 group encoder. It keeps its own
// bit collector, predicts the characters each accepted byte request causes and
// compares every accepted character request against the oldest prediction.
// ----------------------------------------------------------------------------
module base59_char_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // final_byte
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [6:0] char_code, [7] zero
  input  logic       m_tlast,   // run_last
  output int         errors,
  output int         pending
);

  localparam int GROUP_LEN = 47;
  localparam int BASE      = 59;
  localparam int GROUP_CHARS = 8;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } char_t;

  // digit alphabet, digit 0 first
  string digit_set = "\ny={9,570123468functio[lshrabdegjkmpqvwxz!#%()]}<>+/*:;.~_ ";

  char_t       chars_due[$];
  logic [63:0] collect_bits;
  int          collect_cnt;
  int          fail_cnt = 0;
  char_t       oldest;

  assign errors = fail_cnt;

  // append the eight characters of one group, lowest digit first
  task automatic queue_group_chars(input logic [46:0] grp, input logic ends_run);
    logic [63:0] val;
    int          idx;
    byte         ch;
    char_t       c;
    val = {17'b0, grp};
    for (int d = 0; d < GROUP_CHARS; d++) begin
      idx    = int'(val % BASE);
      val    = val / BASE;
      ch     = digit_set[idx];
      c.code = ch[6:0];
      c.last = ends_run && (d == GROUP_CHARS - 1);
      chars_due.insert(chars_due.size(), c);
    end
  endtask

  // fold one byte into the collector and predict what it releases
  task automatic encode_byte(input logic [7:0] data, input logic fin);
    logic        full;
    logic        pad;
    logic [46:0] first_grp;
    if (collect_cnt > GROUP_LEN - 1) collect_cnt = GROUP_LEN - 1;
    collect_bits &= (64'd1 << collect_cnt) - 64'd1;
    collect_bits |= {56'b0, data} << collect_cnt;
    collect_cnt  += 8;
    full      = (collect_cnt >= GROUP_LEN);
    first_grp = collect_bits[46:0];
    if (full) begin
      collect_bits = collect_bits >> GROUP_LEN;
      collect_cnt  = collect_cnt - GROUP_LEN;
    end
    pad = fin && (collect_cnt > 0);
    if (full) queue_group_chars(first_grp, !pad);
    if (pad) queue_group_chars(collect_bits[46:0], 1'b1);
    if (fin) begin
      collect_bits = '0;
      collect_cnt  = 0;
    end
  endtask

  // compare outgoing characters, then predict for incoming bytes
  always @(posedge clk) begin
    if (rst) begin
      chars_due.delete();
      collect_bits = '0;
      collect_cnt  = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (chars_due.size() == 0) begin
          $error("unexpected character request: char_code %0d run_last %0b",
                 m_tdata[6:0], m_tlast);
          fail_cnt++;
        end else begin
          oldest = chars_due.pop_front();
          if (m_tdata[6:0] !== oldest.code) begin
            $error("char_code mismatch: expected %0d, actual %0d", oldest.code, m_tdata[6:0]);
            fail_cnt++;
          end
          if (m_tlast !== oldest.last) begin
            $error("run_last mismatch: expected %0b, actual %0b", oldest.last, m_tlast);
            fail_cnt++;
          end
          if (m_tdata[7] !== 1'b0) begin
            $error("tdata pad bit mismatch: expected 0, actual %0b", m_tdata[7]);
            fail_cnt++;
          end
        end
      end
      if (s_tvalid && s_tready) encode_byte(s_tdata, s_tlast);
    end
    pending <= chars_due.size();
  end

endmodule

// File: test/tb_base59_group_encoder_core.sv
// ----------------------------------------------------------------------------
// tb_base59_group_encoder_core
// Drives byte streams into the base-59 group encoder with bursty input and a
// stalling output, including a long output hold-off and a full drain, and
// reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_base59_group_encoder_core;

  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int BYTE_TARGET = 200;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_SPARSE,
    RX_BEAT
  } rx_mode_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  int         errors;
  int         pending;

  int         burst_left;
  int         bytes_sent;
  int         idle_cycles = 0;
  logic       hold_toggle;
  logic       hold_seen = 1'b0;
  int         hold_cnt = 0;
  rx_mode_t   rx_mode = RX_FREE;
  int         rx_left = 0;
  logic [7:0] beat_cnt = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  base59_group_encoder_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  base59_char_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .errors   (errors),
    .pending  (pending)
  );

  // receiver: random stall modes, plus a long hold-off on request
  always @(posedge clk) begin
    beat_cnt <= beat_cnt + 8'd1;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_seen != hold_toggle) begin
      hold_seen <= hold_toggle;
      hold_cnt  <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
        rx_left <= $urandom_range(10, 80);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_FREE:   m_tready <= 1'b1;
        RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: m_tready <= ($urandom_range(0, 4) == 0);
        default:   m_tready <= (beat_cnt[2:0] != 3'd0) && (beat_cnt[2:0] != 3'd5);
      endcase
    end
  end

  // watchdog on cycles without any accepted request
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // offer one byte request and wait for it to be taken, gap after a burst
  task automatic send_byte(input logic [7:0] data, input logic fin);
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tlast  <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
    end
  endtask

  // random byte, biased toward all zeros and all ones
  function automatic logic [7:0] pick_byte();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return 8'h00;
    if (sel == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_stream(input int len, input logic ends_final);
    for (int i = 0; i < len; i++) send_byte(pick_byte(), ends_final && (i == len - 1));
  endtask

  // stop offering until every predicted character has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic held;
    logic paused;
    int   len;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = 8'h00;
    s_tlast     = 1'b0;
    hold_toggle = 1'b0;
    burst_left  = 4;
    bytes_sent  = 0;
    held        = 1'b0;
    paused      = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // single final bytes at both extremes
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // all-ones group completed by the final byte, plus a one-bit padded group
    repeat (5) send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // bytes without output, a group completed mid stream, then a padded final
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h7F, 1'b1);
    drain();

    // 47 bytes fill exactly eight groups, so the final byte leaves nothing to pad
    send_stream(47, 1'b1);

    // random streams, mostly closed by a final byte
    while (bytes_sent < BYTE_TARGET) begin
      if (!held && bytes_sent >= 80) begin
        hold_toggle <= ~hold_toggle;
        held = 1'b1;
      end
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : $urandom_range(7, 60);
      if (len > BYTE_TARGET - bytes_sent) len = BYTE_TARGET - bytes_sent;
      send_stream(len, ($urandom_range(0, 4) != 0));
      if (!paused && bytes_sent >= 140) begin
        drain();
        paused = 1'b1;
      end
    end

    // end of run: wait out everything still owed
    drain();
    repeat (250) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: base59_group_encoder_core.f
sv/b59_pkg.sv
sv/b59_div_step.sv
sv/base59_group_encoder_core.sv
test/base59_char_checker.sv
test/tb_base59_group_encoder_core.sv
